// ----- hdl/oqdbv_pkg.sv -----
package oqdbv_pkg;

  localparam int unsigned CmdWidth    = 3;
  localparam int unsigned StatusWidth = 3;

  typedef enum logic [CmdWidth-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_POP        = 3'd2,
    CMD_ITER_NEXT  = 3'd3,
    CMD_ITER_RESET = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ITER_END  = 3'd4
  } status_e;

  // Per-cycle operation broadcast to every cell of the chain.
  typedef struct packed {
    logic append;
    logic remove;
    logic pop;
  } cell_ctrl_t;

endpackage

// ----- hdl/oqdbv_cell.sv -----
module oqdbv_cell #(
  parameter int unsigned Idx        = 0,
  parameter int unsigned DataWidth  = 32,
  parameter int unsigned CountWidth = 5
) (
  input  logic                   clk_i,
  input  oqdbv_pkg::cell_ctrl_t  ctrl_i,
  input  logic [DataWidth-1:0]   value_i,
  input  logic [CountWidth-1:0]  count_i,
  input  logic [CountWidth-1:0]  iter_pos_i,
  input  logic [DataWidth-1:0]   next_data_i,
  input  logic                   match_i,
  output logic                   match_o,
  output logic [DataWidth-1:0]   data_o,
  output logic [DataWidth-1:0]   iter_tap_o,
  output logic [DataWidth-1:0]   tail_tap_o,
  output logic                   below_iter_o
);
  import oqdbv_pkg::*;

  localparam logic [CountWidth-1:0] IdxC  = CountWidth'(Idx);
  localparam logic [CountWidth-1:0] IdxP1 = CountWidth'(Idx + 1);

  logic [DataWidth-1:0] data_q, data_d;
  logic                 occupied;
  logic                 hit;
  logic                 shift;

  assign occupied = IdxC < count_i;
  assign hit      = occupied && (data_q == value_i);
  assign match_o  = match_i | hit;

  // Every cell at or behind the removed entry takes the word of its neighbor.
  assign shift = ctrl_i.pop | (ctrl_i.remove & match_o);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.append && (IdxC == count_i)) begin
      data_d = value_i;
    end else if (shift) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o       = data_q;
  assign iter_tap_o   = (IdxC == iter_pos_i) ? data_q : '0;
  assign tail_tap_o   = (IdxP1 == count_i) ? data_q : '0;
  assign below_iter_o = hit && !match_i && (IdxC < iter_pos_i);

endmodule

// ----- hdl/ordered_queue_delete_by_value_unit.sv -----
// Ordered queue of up to DEPTH words kept in a chain of cells, oldest at cell zero. In the
// cycle a command is taken, every cell compares against the search value and shifts toward
// the head when an entry ahead of it leaves; the result beat is formed in the next cycle from
// the updated cells, and no new command is taken while that result is pending. The
// first-match search ripples through the cells, which bounds the clock for large DEPTH.
module ordered_queue_delete_by_value_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [oqdbv_pkg::CmdWidth-1:0]  command_i,
  input  logic [DATA_WIDTH-1:0]           value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [oqdbv_pkg::StatusWidth-1:0] status_o,
  output logic [DATA_WIDTH-1:0]           data_out_o,
  output logic [$clog2(DEPTH+1)-1:0]      entry_count_o,
  output logic [DATA_WIDTH-1:0]           head_value_o,
  output logic [DATA_WIDTH-1:0]           tail_value_o,
  output logic                            was_started_o
);
  import oqdbv_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  cell_ctrl_t ctrl;
  cmd_e       cmd;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] iter_pos_q, iter_pos_d, pos_eff;
  logic          iter_active_q, iter_active_d;

  logic                  pend_q, pend_d;
  status_e               pend_status_q, pend_status_d;
  logic [DATA_WIDTH-1:0] pend_data_q, pend_data_d;
  logic                  pend_started_q, pend_started_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q;
  logic [DATA_WIDTH-1:0] out_data_q, out_head_q, out_tail_q;
  logic [CW-1:0]         out_count_q;
  logic                  out_started_q;

  logic                  accept;
  logic                  out_load;
  logic                  found;
  logic                  below_iter;
  logic [DATA_WIDTH-1:0] iter_data;
  logic [DATA_WIDTH-1:0] tail_data;
  logic [DATA_WIDTH-1:0] head_data;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] iter_taps  [DEPTH];
  logic [DATA_WIDTH-1:0] tail_taps  [DEPTH];
  logic                  below_taps [DEPTH];
  logic                  match      [DEPTH+1];

  assign in_ready_o = !pend_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = pend_q && (!out_valid_q || out_ready_i);
  assign cmd        = cmd_e'(command_i);
  assign pos_eff    = iter_active_q ? iter_pos_q : '0;

  assign match[0] = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] next_data;
    if (k == DEPTH - 1) begin : g_last
      assign next_data = cell_data[k];
    end else begin : g_mid
      assign next_data = cell_data[k+1];
    end

    oqdbv_cell #(
      .Idx       (k),
      .DataWidth (DATA_WIDTH),
      .CountWidth(CW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .value_i     (value_i),
      .count_i     (count_q),
      .iter_pos_i  (pos_eff),
      .next_data_i (next_data),
      .match_i     (match[k]),
      .match_o     (match[k+1]),
      .data_o      (cell_data[k]),
      .iter_tap_o  (iter_taps[k]),
      .tail_tap_o  (tail_taps[k]),
      .below_iter_o(below_taps[k])
    );
  end

  assign found     = match[DEPTH];
  assign head_data = (count_q != '0) ? cell_data[0] : '0;

  always_comb begin
    iter_data  = '0;
    tail_data  = '0;
    below_iter = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      iter_data  = iter_data | iter_taps[k];
      tail_data  = tail_data | tail_taps[k];
      below_iter = below_iter | below_taps[k];
    end
  end

  always_comb begin
    ctrl           = '0;
    count_d        = count_q;
    iter_pos_d     = iter_pos_q;
    iter_active_d  = iter_active_q;
    pend_d         = pend_q;
    pend_status_d  = pend_status_q;
    pend_data_d    = pend_data_q;
    pend_started_d = pend_started_q;
    if (out_load) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      pend_d         = 1'b1;
      pend_status_d  = ST_OK;
      pend_data_d    = '0;
      pend_started_d = 1'b0;
      case (cmd)
        CMD_APPEND: begin
          if (count_q == DepthC) begin
            pend_status_d = ST_FULL;
          end else begin
            ctrl.append = 1'b1;
            count_d     = count_q + OneC;
          end
        end
        CMD_REMOVE: begin
          ctrl.remove = 1'b1;
          if (found) begin
            count_d = count_q - OneC;
            if (iter_active_q && below_iter) begin
              iter_pos_d = iter_pos_q - OneC;
            end
          end else begin
            pend_status_d = ST_NOT_FOUND;
          end
        end
        CMD_POP: begin
          if (count_q == '0) begin
            pend_status_d = ST_EMPTY;
          end else begin
            ctrl.pop    = 1'b1;
            pend_data_d = cell_data[0];
            count_d     = count_q - OneC;
            if (iter_active_q && (iter_pos_q != '0)) begin
              iter_pos_d = iter_pos_q - OneC;
            end
          end
        end
        CMD_ITER_NEXT: begin
          if (pos_eff < count_q) begin
            pend_data_d   = iter_data;
            iter_pos_d    = pos_eff + OneC;
            iter_active_d = 1'b1;
          end else begin
            pend_status_d = ST_ITER_END;
            iter_pos_d    = pos_eff;
            iter_active_d = 1'b0;
          end
        end
        CMD_ITER_RESET: begin
          pend_started_d = iter_active_q;
          iter_active_d  = 1'b0;
        end
        CMD_CLEAR: begin
          count_d       = '0;
          iter_pos_d    = '0;
          iter_active_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      iter_pos_q    <= '0;
      iter_active_q <= 1'b0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      count_q       <= count_d;
      iter_pos_q    <= iter_pos_d;
      iter_active_q <= iter_active_d;
      pend_q        <= pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q  <= pend_status_d;
    pend_data_q    <= pend_data_d;
    pend_started_q <= pend_started_d;
    if (out_load) begin
      out_status_q  <= pend_status_q;
      out_data_q    <= pend_data_q;
      out_started_q <= pend_started_q;
      out_count_q   <= count_q;
      out_head_q    <= head_data;
      out_tail_q    <= tail_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign data_out_o    = out_data_q;
  assign entry_count_o = out_count_q;
  assign head_value_o  = out_head_q;
  assign tail_value_o  = out_tail_q;
  assign was_started_o = out_started_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count exceeds depth");

  a_iter_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_active_q |-> (iter_pos_q <= count_q))
    else $error("active iterator points past the tail");

  a_pend_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("pending result while output beat still held");

  a_accept_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q)
    else $error("accepted command produced no pending result");

endmodule
